[hdl/spq_pkg.sv]
// Package for the sorted priority queue: commands, status codes, states and cell control.
`default_nettype none
package spq_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int VALUE_W      = 32;
    localparam int FIELD_W      = 5;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 48;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOTFOUND = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_RESULT
    } state_t;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic cmp;   // latch compare flags against the broadcast value
        logic ins;   // shift right of the insert point, write the value there
        logic rem;   // shift left from the first match onward
    } cell_ctl_t;

endpackage
`default_nettype wire

[hdl/spq_cell.sv]
// One storage cell of the sorted row: holds an entry, its valid bit and compare flags.
`default_nettype none
module spq_cell
    import spq_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cell_ctl_t                 ctl,
    input  wire logic signed [VALUE_W-1:0] item_value,
    input  wire logic                      left_le,
    input  wire logic                      left_lt,
    input  wire logic signed [VALUE_W-1:0] left_value,
    input  wire logic                      left_valid,
    input  wire logic signed [VALUE_W-1:0] right_value,
    input  wire logic                      right_valid,
    output logic                           le,
    output logic                           lt,
    output logic signed [VALUE_W-1:0]      value,
    output logic                           valid,
    output logic                           ins_mark,
    output logic                           hit_mark
);

    logic signed [VALUE_W-1:0] value_reg;
    logic                      valid_reg;
    logic                      le_reg;
    logic                      lt_reg;

    // Hold compare flags and the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            le_reg    <= 1'b0;
            lt_reg    <= 1'b0;
        end else begin
            if (ctl.cmp) begin
                le_reg <= valid_reg && (value_reg <= item_value);
                lt_reg <= valid_reg && (value_reg < item_value);
            end
            if (ctl.ins && !le_reg) begin
                valid_reg <= left_le ? 1'b1 : left_valid;
            end else if (ctl.rem && !lt_reg) begin
                valid_reg <= right_valid;
            end
        end
    end

    // Take the new value at the insert point, the left entry beyond it,
    // or the right entry from the removed entry onward
    always_ff @(posedge aclk) begin
        if (ctl.ins && !le_reg) begin
            value_reg <= left_le ? item_value : left_value;
        end else if (ctl.rem && !lt_reg) begin
            value_reg <= right_value;
        end
    end

    assign le       = le_reg;
    assign lt       = lt_reg;
    assign value    = value_reg;
    assign valid    = valid_reg;
    assign ins_mark = left_le && !le_reg;
    assign hit_mark = left_lt && !lt_reg && le_reg;

endmodule
`default_nettype wire

[hdl/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue: command channel, cell row and result register.
//
// Usage: each item on the s_ channel carries a command (insert, remove,
// find) and a signed 32-bit value; each item yields exactly one result on
// the m_ channel with status, position, head value, empty flag and count.
// Entries live in a row of CAPACITY cells kept in ascending order; every
// cell compares against the broadcast value in parallel and trades entries
// with its neighbors when the row shifts.
// Timing: the accept edge latches all compare flags, ST_APPLY shifts the row and
// updates the count, and ST_RESULT loads the result register once its slot is
// free. A new item is taken once the previous one reaches the result register;
// the row's compare-then-shift pair sets this.
// A stalled receiver holds the result register; the next item may still be
// accepted and worked up to its result load, where it waits for the slot.
// Reset (aresetn low, synchronous) empties the queue and drops any result.
`default_nettype none
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] cmd, [33:2] item_value, [39:34] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] status, [6:2] position, [38:7] head_value, [39] is_empty,
    // [44:40] entry_count, [47:45] zero
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;

    logic [1:0]                cmd_reg;
    logic signed [VALUE_W-1:0] item_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [1:0]                status_reg, status_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    logic                      s_accept;
    logic                      full;
    logic                      hit;
    logic                      load_result;
    logic [IDX_W-1:0]          ins_pos;
    logic [IDX_W-1:0]          hit_pos;
    logic signed [VALUE_W-1:0] bcast_value;
    cell_ctl_t                 ctl;

    logic [CAPACITY-1:0]               le_vec;
    logic [CAPACITY-1:0]               lt_vec;
    logic [CAPACITY-1:0]               valid_vec;
    logic [CAPACITY-1:0]               ins_mark_vec;
    logic [CAPACITY-1:0]               hit_mark_vec;
    logic signed [VALUE_W-1:0]         value_vec [CAPACITY];

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign load_result = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    // Compare against the incoming value at acceptance, write the held one later
    assign bcast_value = s_accept ? s_tdata[33:2] : item_reg;

    assign ctl.cmp = s_accept;
    assign ctl.ins = (state_reg == ST_APPLY) && (cmd_reg == CMD_INSERT) && !full;
    assign ctl.rem = (state_reg == ST_APPLY) && (cmd_reg == CMD_REMOVE) && hit;

    // Build the cell row; the ends see a closed boundary
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      l_le, l_lt, l_valid, r_valid;
        logic signed [VALUE_W-1:0] l_value, r_value;

        if (i == 0) begin : g_first
            assign l_le    = 1'b1;
            assign l_lt    = 1'b1;
            assign l_value = '0;
            assign l_valid = 1'b0;
        end else begin : g_inner_l
            assign l_le    = le_vec[i-1];
            assign l_lt    = lt_vec[i-1];
            assign l_value = value_vec[i-1];
            assign l_valid = valid_vec[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign r_value = '0;
            assign r_valid = 1'b0;
        end else begin : g_inner_r
            assign r_value = value_vec[i+1];
            assign r_valid = valid_vec[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .item_value  (bcast_value),
            .left_le     (l_le),
            .left_lt     (l_lt),
            .left_value  (l_value),
            .left_valid  (l_valid),
            .right_value (r_value),
            .right_valid (r_valid),
            .le          (le_vec[i]),
            .lt          (lt_vec[i]),
            .value       (value_vec[i]),
            .valid       (valid_vec[i]),
            .ins_mark    (ins_mark_vec[i]),
            .hit_mark    (hit_mark_vec[i])
        );
    end

    // Encode the one-hot boundary marks into positions
    always_comb begin
        ins_pos = '0;
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (ins_mark_vec[i]) ins_pos = ins_pos | IDX_W'(i);
            if (hit_mark_vec[i]) hit_pos = hit_pos | IDX_W'(i);
        end
    end
    assign hit = |hit_mark_vec;

    // Next state, status, position and count
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                state_next  = ST_RESULT;
                status_next = STATUS_NOTFOUND;
                pos_next    = '0;
                case (cmd_reg)
                    CMD_INSERT: begin
                        if (full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            status_next = STATUS_OK;
                            pos_next    = ins_pos;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (hit) begin
                            status_next = STATUS_OK;
                            pos_next    = hit_pos;
                            count_next  = count_reg - 1'b1;
                        end
                    end
                    CMD_FIND: begin
                        if (hit) begin
                            status_next = STATUS_OK;
                            pos_next    = hit_pos;
                        end
                    end
                    default: begin
                        status_next = STATUS_NOTFOUND;
                    end
                endcase
            end
            ST_RESULT: begin
                if (load_result) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state and the entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Hold the command and the per-item outcome
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_tdata[1:0];
            item_reg <= s_tdata[33:2];
        end
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    // Result register: load when the slot frees, drop on handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            m_tdata_reg <= {3'b000, FIELD_W'(count_reg), (count_reg == '0),
                            (valid_vec[0] ? value_vec[0] : {VALUE_W{1'b0}}),
                            FIELD_W'(pos_reg), status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The count never passes the row length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Valid cells match the count
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(count_reg))
        else $error("valid cells disagree with entry count");

    // At most one insert point in the row
    a_ins_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> $onehot0(ins_mark_vec))
        else $error("multiple insert points");

    // An accepted item moves on to the shift cycle
    a_accept_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_APPLY))
        else $error("accepted item not applied");

endmodule
`default_nettype wire
